/* rtl/source_param_stream_monitor_unit_assert.svh */
// ----------------------------------------------------------------------------
// Source parameter stream monitor: assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SOURCE_PARAM_STREAM_MONITOR_UNIT_ASSERT_SVH
`define SOURCE_PARAM_STREAM_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPSM_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spsm_pkg.sv */
// ----------------------------------------------------------------------------
// Source parameter stream monitor package
// Sizes, constants and register indexes of the stream monitor.
// ----------------------------------------------------------------------------
package spsm_pkg;

  localparam int unsigned STORE_DEPTH         = 8;
  localparam int unsigned CONFIG_REPEAT_LIMIT = 3;

  localparam int unsigned IDX_W    = $clog2(STORE_DEPTH + 1);
  localparam int unsigned NUM_CH   = 5;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned VAL_W    = 10;
  localparam int unsigned DATA_W   = 6;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LINK_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 50;

  localparam logic [BYTE_W-1:0] DATA_FLAG  = 8'h80;
  localparam logic [DATA_W-1:0] DATA_MASK  = 6'h3f;
  localparam logic [3:0]        HIGH_MASK  = 4'hf;
  localparam logic [CNT_W-1:0]  REPEAT_LIMIT = CNT_W'(CONFIG_REPEAT_LIMIT);
  localparam logic [NUM_CH-1:0] ALL_FLAGS  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_CODES  = 3'd0,
    CFG_LOWER_BOUNDS   = 3'd1,
    CFG_UPPER_BOUNDS   = 3'd2,
    CFG_FINE_LIMIT     = 3'd3,
    CFG_TUNE_LIMIT     = 3'd4,
    CFG_SAMPLE_TIMEOUT = 3'd5,
    CFG_LINK_MIN_BYTES = 3'd6,
    CFG_REPEAT_BYTE    = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

endpackage

/* rtl/source_param_stream_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Source parameter stream monitor
// Parses a serial byte stream into channel values, range-checks them and
// tracks link activity, regulation status and configuration requests.
// ----------------------------------------------------------------------------
// Path: input transfer into the input register, then one pass through the
// decode logic into the state and result registers.
// Throughput: one item per cycle while the output is not stalled, set by the single update pass.
// Reset: asynchronous; clears the data store, the configuration registers and all
// other state but the input register's payload to their defaults; no clearing pass.
module source_param_stream_monitor_unit
  import spsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  logic                  line_error_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VAL_W-1:0]      decoded_value_o,
  output logic [NUM_CH-1:0]     range_flags_o,
  output logic [VAL_W-1:0]      change_abs_o,
  output logic                  fine_regulation_o,
  output logic                  link_good_o,
  output logic                  block_done_o,
  output logic                  config_request_o,
  output logic                  rx_fault_o,
  output logic                  regulation_ok_o
);

  logic [NUM_CH*CODE_W-1:0] codes_q;
  logic [NUM_CH*VAL_W-1:0]  lower_q;
  logic [NUM_CH*VAL_W-1:0]  upper_q;
  logic [VAL_W-1:0]         fine_lim_q;
  logic [VAL_W-1:0]         tune_lim_q;
  logic [CNT_W-1:0]         timeout_q;
  logic [LINK_W-1:0]        link_min_q;
  logic [BYTE_W-1:0]        cfg_char_q;

  logic                     s1_valid_q;
  req_type_e                s1_req_q;
  logic [BYTE_W-1:0]        s1_byte_q;
  logic                     s1_err_q;

  logic                     out_valid_q, out_valid_d;
  logic                     done_q, done_d;
  logic                     request_q, request_d;

  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [DATA_W-1:0]        store_q [STORE_DEPTH];
  logic [DATA_W-1:0]        store_d [STORE_DEPTH];
  logic [CODE_W-1:0]        prev_code_q, prev_code_d;
  logic [CNT_W-1:0]         miss_q [NUM_CH];
  logic [CNT_W-1:0]         miss_d [NUM_CH];
  logic [NUM_CH-1:0]        flags_q, flags_d;
  logic [VAL_W-1:0]         prev_val_q, prev_val_d;
  logic [VAL_W-1:0]         change_q, change_d;
  logic [LINK_W-1:0]        byte_cnt_q, byte_cnt_d;
  logic                     link_q, link_d;
  logic [CNT_W-1:0]         repeat_q, repeat_d;
  logic                     fine_q, fine_d;
  logic                     error_q, error_d;
  logic                     in_reg_q, in_reg_d;
  logic [VAL_W-1:0]         decoded_q, decoded_d;

  logic                     advance;
  logic [BYTE_W-1:0]        byte_v;
  logic [VAL_W-1:0]         value_v;
  logic [NUM_CH-1:0]        serve;
  logic [NUM_CH-1:0]        in_rng;
  logic [CNT_W-1:0]         miss_inc [NUM_CH];
  logic [CNT_W-1:0]         repeat_inc;
  logic [VAL_W-1:0]         diff_v;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q    <= '0;
      lower_q    <= '0;
      upper_q    <= '1;
      fine_lim_q <= '0;
      tune_lim_q <= '0;
      timeout_q  <= '0;
      link_min_q <= '0;
      cfg_char_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNEL_CODES:  codes_q    <= cfg_wdata_i[NUM_CH*CODE_W-1:0];
        CFG_LOWER_BOUNDS:   lower_q    <= cfg_wdata_i[NUM_CH*VAL_W-1:0];
        CFG_UPPER_BOUNDS:   upper_q    <= cfg_wdata_i[NUM_CH*VAL_W-1:0];
        CFG_FINE_LIMIT:     fine_lim_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_TUNE_LIMIT:     tune_lim_q <= cfg_wdata_i[VAL_W-1:0];
        CFG_SAMPLE_TIMEOUT: timeout_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_LINK_MIN_BYTES: link_min_q <= cfg_wdata_i[LINK_W-1:0];
        CFG_REPEAT_BYTE:    cfg_char_q <= cfg_wdata_i[BYTE_W-1:0];
        default:            codes_q    <= codes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q  <= req_type_e'(req_type_i);
      s1_byte_q <= rx_byte_i;
      s1_err_q  <= line_error_i;
    end
  end

  always_comb begin
    byte_v  = s1_err_q ? '0 : s1_byte_q;
    value_v = {store_q[0][3:0] & HIGH_MASK, store_q[1] & DATA_MASK};
    serve   = '0;
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (prev_code_q == codes_q[CODE_W*i +: CODE_W]) begin
        serve    = '0;
        serve[i] = 1'b1;
      end
    end
    for (int i = 0; i < NUM_CH; i++) begin
      in_rng[i]   = (value_v > lower_q[VAL_W*i +: VAL_W]) &&
                    (value_v < upper_q[VAL_W*i +: VAL_W]);
      miss_inc[i] = miss_q[i] + CNT_W'(1);
    end
    repeat_inc = repeat_q + CNT_W'(1);
    diff_v     = (value_v >= prev_val_q) ? value_v - prev_val_q : prev_val_q - value_v;

    idx_d       = idx_q;
    store_d     = store_q;
    prev_code_d = prev_code_q;
    miss_d      = miss_q;
    flags_d     = flags_q;
    prev_val_d  = prev_val_q;
    change_d    = change_q;
    byte_cnt_d  = byte_cnt_q;
    link_d      = link_q;
    repeat_d    = repeat_q;
    fine_d      = fine_q;
    error_d     = error_q;
    in_reg_d    = in_reg_q;
    decoded_d   = decoded_q;
    done_d      = 1'b0;
    request_d   = 1'b0;

    unique case (s1_req_q)
      REQ_BYTE: begin
        byte_cnt_d = byte_cnt_q + LINK_W'(1);
        if (s1_err_q) begin
          error_d = 1'b1;
        end
        if (byte_v == cfg_char_q) begin
          error_d = 1'b1;
          if (repeat_inc > REPEAT_LIMIT) begin
            request_d = 1'b1;
            repeat_d  = '0;
          end else begin
            repeat_d = repeat_inc;
          end
        end else begin
          repeat_d = '0;
        end
        if ((byte_v & DATA_FLAG) != '0) begin
          for (int i = 0; i < STORE_DEPTH; i++) begin
            if (idx_q == IDX_W'(i + 1)) begin
              store_d[i] = byte_v[DATA_W-1:0] & DATA_MASK;
            end
          end
          idx_d = (idx_q == IDX_W'(STORE_DEPTH)) ? IDX_W'(1) : idx_q + IDX_W'(1);
        end else begin
          idx_d     = IDX_W'(1);
          decoded_d = value_v;
          for (int i = 0; i < NUM_CH; i++) begin
            if (serve[i]) begin
              miss_d[i] = miss_inc[i];
              if (miss_inc[i] > timeout_q) begin
                flags_d[i] = 1'b0;
              end
              if (in_rng[i]) begin
                flags_d[i] = 1'b1;
                miss_d[i]  = '0;
              end
            end
          end
          if (serve[0]) begin
            if (in_rng[0]) begin
              change_d   = diff_v;
              prev_val_d = value_v;
              if (diff_v <= fine_lim_q) begin
                if (in_reg_q) begin
                  fine_d = 1'b1;
                end
              end else begin
                fine_d = 1'b0;
              end
            end else begin
              fine_d = 1'b0;
            end
          end
          if (serve[NUM_CH-1]) begin
            done_d   = 1'b1;
            in_reg_d = (flags_d == ALL_FLAGS) && (change_d <= tune_lim_q);
          end
          prev_code_d = byte_v[CODE_W-1:0];
        end
      end
      REQ_TICK: begin
        if (byte_cnt_q > link_min_q) begin
          link_d     = 1'b1;
          byte_cnt_d = '0;
        end else begin
          link_d  = 1'b0;
          flags_d = '0;
          fine_d  = 1'b0;
        end
        error_d = 1'b0;
      end
      default: begin
        error_d = error_q;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      request_q   <= 1'b0;
      idx_q       <= IDX_W'(1);
      prev_code_q <= '0;
      flags_q     <= '0;
      prev_val_q  <= '0;
      change_q    <= '0;
      byte_cnt_q  <= '0;
      link_q      <= 1'b0;
      repeat_q    <= '0;
      fine_q      <= 1'b1;
      error_q     <= 1'b1;
      in_reg_q    <= 1'b0;
      decoded_q   <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CH; i++) begin
        miss_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        done_q      <= done_d;
        request_q   <= request_d;
        idx_q       <= idx_d;
        store_q     <= store_d;
        prev_code_q <= prev_code_d;
        miss_q      <= miss_d;
        flags_q     <= flags_d;
        prev_val_q  <= prev_val_d;
        change_q    <= change_d;
        byte_cnt_q  <= byte_cnt_d;
        link_q      <= link_d;
        repeat_q    <= repeat_d;
        fine_q      <= fine_d;
        error_q     <= error_d;
        in_reg_q    <= in_reg_d;
        decoded_q   <= decoded_d;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign decoded_value_o   = decoded_q;
  assign range_flags_o     = flags_q;
  assign change_abs_o      = change_q;
  assign fine_regulation_o = fine_q;
  assign link_good_o       = link_q;
  assign block_done_o      = done_q;
  assign config_request_o  = request_q;
  assign rx_fault_o        = error_q;
  assign regulation_ok_o   = in_reg_q;

endmodule

/* rtl/spsm_checker.sv */
// ----------------------------------------------------------------------------
// Source parameter stream monitor checker
// Port-level assertions on the stream monitor, attached by bind.
// ----------------------------------------------------------------------------
`include "source_param_stream_monitor_unit_assert.svh"

module spsm_checker
  import spsm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [VAL_W-1:0]      decoded_value_o,
  input logic [NUM_CH-1:0]     range_flags_o,
  input logic [VAL_W-1:0]      change_abs_o,
  input logic                  block_done_o,
  input logic                  config_request_o,
  input logic                  rx_fault_o,
  input logic                  regulation_ok_o
);

  logic [1:0] pending_q, pending_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q + 2'(in_xfer) - 2'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `SPSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(decoded_value_o) && $stable(range_flags_o) &&
    $stable(change_abs_o) && $stable(block_done_o) && $stable(config_request_o),
    "result changed while stalled")
  `SPSM_ASSERT(a_pending, clk_i, rst_ni, out_valid_o || pending_q != 2'd0,
    pending_q != 2'd3 && (!out_valid_o || pending_q != 2'd0),
    "result count does not match transfers")
  `SPSM_ASSERT(a_request_err, clk_i, rst_ni, out_valid_o && config_request_o,
    rx_fault_o, "config request without receive fault")
  `SPSM_ASSERT(a_reg_flags, clk_i, rst_ni, out_valid_o && block_done_o && regulation_ok_o,
    range_flags_o == ALL_FLAGS, "regulation set with flags missing")

endmodule

bind source_param_stream_monitor_unit spsm_checker u_spsm_checker (.*);

/* bench/source_param_stream_monitor_unit_tb.sv */
// ----------------------------------------------------------------------------
// Stream monitor testbench
// Streams serial bytes and ticks into the monitor under several register
// settings and compares every status transfer, field by field, against a
// cycle-free model of the parser, channel range checks and link logic.
// ----------------------------------------------------------------------------
module source_param_stream_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spsm_pkg::*;

  typedef struct {
    logic [VAL_W-1:0]  decoded_value;
    logic [NUM_CH-1:0] range_flags;
    logic [VAL_W-1:0]  change_abs;
    logic              fine_regulation;
    logic              link_good;
    logic              block_done;
    logic              config_request;
    logic              rx_fault;
    logic              regulation_ok;
  } status_t;

  class status_board;
    logic [NUM_CH*CODE_W-1:0] chan_codes = '0;
    logic [NUM_CH*VAL_W-1:0]  lower_bounds = '0;
    logic [NUM_CH*VAL_W-1:0]  upper_bounds = '1;
    logic [VAL_W-1:0]         fine_limit = '0;
    logic [VAL_W-1:0]         tune_limit = '0;
    logic [CNT_W-1:0]         sample_timeout = '0;
    logic [LINK_W-1:0]        link_min = '0;
    logic [BYTE_W-1:0]        repeat_byte = '0;

    logic [IDX_W-1:0]  write_ptr = IDX_W'(1);
    logic [DATA_W-1:0] samples [STORE_DEPTH+1];
    logic [BYTE_W-1:0] last_code_seen = '0;
    logic [CNT_W-1:0]  miss_count [NUM_CH];
    logic [NUM_CH-1:0] in_range = '0;
    logic [VAL_W-1:0]  ch0_value = '0;
    logic [VAL_W-1:0]  ch0_change = '0;
    logic [LINK_W-1:0] bytes_seen = '0;
    logic              link_up = 1'b0;
    logic [CNT_W-1:0]  repeat_run = '0;
    logic              fine_ind = 1'b1;
    logic              err_ind = 1'b1;
    logic              regulating = 1'b0;
    logic [VAL_W-1:0]  value_out = '0;

    status_t expected_status[$];
    int      mismatches = 0;

    function new();
      foreach (samples[i]) samples[i] = '0;
      foreach (miss_count[i]) miss_count[i] = '0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] word);
      case (idx)
        CFG_CHANNEL_CODES:  chan_codes = word[NUM_CH*CODE_W-1:0];
        CFG_LOWER_BOUNDS:   lower_bounds = word;
        CFG_UPPER_BOUNDS:   upper_bounds = word;
        CFG_FINE_LIMIT:     fine_limit = word[VAL_W-1:0];
        CFG_TUNE_LIMIT:     tune_limit = word[VAL_W-1:0];
        CFG_SAMPLE_TIMEOUT: sample_timeout = word[CNT_W-1:0];
        CFG_LINK_MIN_BYTES: link_min = word[LINK_W-1:0];
        CFG_REPEAT_BYTE:    repeat_byte = word[BYTE_W-1:0];
      endcase
    endfunction

    // lowest channel wins on duplicate codes
    function int channel_for(logic [BYTE_W-1:0] code);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (code == {1'b0, chan_codes[CODE_W*ch +: CODE_W]}) return ch;
      end
      return -1;
    endfunction

    function void take_item(req_type_e kind, logic [BYTE_W-1:0] rx, logic bad);
      status_t           s;
      logic [BYTE_W-1:0] b;
      logic [VAL_W-1:0]  lo;
      logic [VAL_W-1:0]  hi;
      int                ch;
      s.block_done = 1'b0;
      s.config_request = 1'b0;
      if (kind == REQ_BYTE) begin
        b = bad ? '0 : rx;
        bytes_seen++;
        if (bad) err_ind = 1'b1;
        if (b == '0) write_ptr = IDX_W'(1);
        if (b == repeat_byte) begin
          err_ind = 1'b1;
          repeat_run++;
          if (repeat_run > REPEAT_LIMIT) begin
            s.config_request = 1'b1;
            repeat_run = '0;
          end
        end else begin
          repeat_run = '0;
        end
        if ((b & DATA_FLAG) != '0) begin
          samples[write_ptr] = b[DATA_W-1:0] & DATA_MASK;
          write_ptr = (write_ptr >= STORE_DEPTH) ? IDX_W'(1) : write_ptr + 1'b1;
        end else begin
          write_ptr = IDX_W'(1);
          value_out = {samples[1][3:0] & HIGH_MASK, samples[2] & DATA_MASK};
          ch = channel_for(last_code_seen);
          if (ch >= 0) begin
            lo = lower_bounds[VAL_W*ch +: VAL_W];
            hi = upper_bounds[VAL_W*ch +: VAL_W];
            miss_count[ch]++;
            if (miss_count[ch] > sample_timeout) in_range[ch] = 1'b0;
            if (value_out > lo && value_out < hi) begin
              in_range[ch] = 1'b1;
              miss_count[ch] = '0;
              if (ch == 0) begin
                ch0_change = (value_out >= ch0_value) ? value_out - ch0_value
                                                      : ch0_value - value_out;
                ch0_value = value_out;
                if (ch0_change > fine_limit) fine_ind = 1'b0;
                else if (regulating) fine_ind = 1'b1;
              end
            end else if (ch == 0) begin
              fine_ind = 1'b0;
            end
            if (ch == NUM_CH - 1) begin
              s.block_done = 1'b1;
              regulating = (in_range == ALL_FLAGS) && (ch0_change <= tune_limit);
            end
          end
          last_code_seen = b;
        end
      end else begin
        if (bytes_seen > link_min) begin
          link_up = 1'b1;
          bytes_seen = '0;
        end else begin
          link_up = 1'b0;
          in_range = '0;
          fine_ind = 1'b0;
        end
        err_ind = 1'b0;
      end
      s.decoded_value = value_out;
      s.range_flags = in_range;
      s.change_abs = ch0_change;
      s.fine_regulation = fine_ind;
      s.link_good = link_up;
      s.rx_fault = err_ind;
      s.regulation_ok = regulating;
      expected_status.push_back(s);
    endfunction

    function void compare_field(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: status transfer with none expected, expected none, actual value %0h",
                 $time, got.decoded_value);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("decoded_value", want.decoded_value, got.decoded_value);
      compare_field("range_flags", want.range_flags, got.range_flags);
      compare_field("change_abs", want.change_abs, got.change_abs);
      compare_field("fine_regulation", want.fine_regulation, got.fine_regulation);
      compare_field("link_good", want.link_good, got.link_good);
      compare_field("block_done", want.block_done, got.block_done);
      compare_field("config_request", want.config_request, got.config_request);
      compare_field("rx_fault", want.rx_fault, got.rx_fault);
      compare_field("regulation_ok", want.regulation_ok, got.regulation_ok);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_BYTE;
  logic [BYTE_W-1:0]     rx_byte = '0;
  logic                  line_error = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_W-1:0]      decoded_value;
  logic [NUM_CH-1:0]     range_flags;
  logic [VAL_W-1:0]      change_abs;
  logic                  fine_regulation;
  logic                  link_good;
  logic                  block_done;
  logic                  config_request;
  logic                  rx_fault;
  logic                  regulation_ok;

  status_board       board = new();
  int                items_sent = 0;
  int                burst_left = 0;
  int                ready_left = 0;
  int                ready_odds = 100;
  logic [BYTE_W-1:0] stream_code = '0;

  source_param_stream_monitor_unit i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .rx_byte_i         (rx_byte),
    .line_error_i      (line_error),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .decoded_value_o   (decoded_value),
    .range_flags_o     (range_flags),
    .change_abs_o      (change_abs),
    .fine_regulation_o (fine_regulation),
    .link_good_o       (link_good),
    .block_done_o      (block_done),
    .config_request_o  (config_request),
    .rx_fault_o        (rx_fault),
    .regulation_ok_o   (regulation_ok)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_odds = 100;
        1: ready_odds = 80;
        2: ready_odds = 40;
        default: ready_odds = 15;
      endcase
      ready_left = $urandom_range(20, 150);
    end
    ready_left--;
    out_ready <= ($urandom_range(0, 99) < ready_odds);
  end

  always @(posedge clk) begin : watch_status
    status_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.decoded_value = decoded_value;
      seen.range_flags = range_flags;
      seen.change_abs = change_abs;
      seen.fine_regulation = fine_regulation;
      seen.link_good = link_good;
      seen.block_done = block_done;
      seen.config_request = config_request;
      seen.rx_fault = rx_fault;
      seen.regulation_ok = regulation_ok;
      board.check_status(seen);
    end
  end

  task automatic send(input req_type_e kind, input logic [BYTE_W-1:0] b, input logic bad);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte <= b;
    line_error <= bad;
    do @(posedge clk); while (!in_ready);
    board.take_item(kind, b, bad);
    items_sent++;
    if (kind == REQ_BYTE) begin
      if (bad) stream_code = '0;
      else if (!b[7]) stream_code = b;
    end
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    burst_left = 0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (board.pending() != 0 && guard < 20000);
    repeat (4) @(posedge clk);
  endtask

  // junk above the register width must be dropped
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'({$urandom(), $urandom()});
    word = (word << width) | value;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    board.set_register(idx, word);
  endtask

  task automatic set_config(input logic [34:0] codes, input logic [49:0] lo,
                            input logic [49:0] hi, input logic [9:0] fine,
                            input logic [9:0] tune, input logic [7:0] tmo,
                            input logic [15:0] link, input logic [7:0] cc);
    write_reg(CFG_CHANNEL_CODES, CFG_DATA_W'(codes), 35);
    write_reg(CFG_LOWER_BOUNDS, lo, 50);
    write_reg(CFG_UPPER_BOUNDS, hi, 50);
    write_reg(CFG_FINE_LIMIT, CFG_DATA_W'(fine), 10);
    write_reg(CFG_TUNE_LIMIT, CFG_DATA_W'(tune), 10);
    write_reg(CFG_SAMPLE_TIMEOUT, CFG_DATA_W'(tmo), 8);
    write_reg(CFG_LINK_MIN_BYTES, CFG_DATA_W'(link), 16);
    write_reg(CFG_REPEAT_BYTE, CFG_DATA_W'(cc), 8);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_settings(input bit dup_codes);
    logic [34:0] codes;
    logic [49:0] lo;
    logic [49:0] hi;
    logic [7:0]  cc;
    int          base;
    int          stride;
    int          l;
    int          h;
    base = $urandom_range(0, 127);
    stride = 2 * $urandom_range(0, 12) + 1;
    for (int i = 0; i < NUM_CH; i++) begin
      codes[CODE_W*i +: CODE_W] = CODE_W'(base + i * stride);
      l = $urandom_range(0, 500);
      if ($urandom_range(0, 5) == 0) h = $urandom_range(0, l);
      else h = l + $urandom_range(2, 520);
      if (h > 1023) h = 1023;
      lo[VAL_W*i +: VAL_W] = VAL_W'(l);
      hi[VAL_W*i +: VAL_W] = VAL_W'(h);
    end
    if (dup_codes) codes[13:7] = codes[6:0];
    case ($urandom_range(0, 3))
      0: cc = 8'($urandom);
      1: cc = {1'b0, codes[CODE_W*$urandom_range(0, 4) +: CODE_W]};
      2: cc = {1'b1, 7'($urandom)};
      default: cc = '0;
    endcase
    set_config(codes, lo, hi, 10'($urandom_range(0, 60)), 10'($urandom_range(0, 120)),
               8'($urandom_range(0, 5)), 16'($urandom_range(0, 10)), cc);
  endtask

  // mostly well-formed frames: two data bytes then the next channel code
  task automatic run_stream(input int count);
    int                stop;
    int                pick;
    int                ch;
    int                nxt;
    int                v;
    int                lo;
    int                hi;
    int                d;
    logic [VAL_W-1:0]  v10;
    logic [BYTE_W-1:0] code;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        send(REQ_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 11) begin
        send(REQ_BYTE, 8'($urandom), 1'($urandom));
      end else if (pick < 14) begin
        repeat ($urandom_range(2, 6)) send(REQ_BYTE, board.repeat_byte, 1'b0);
      end else if (pick < 16) begin
        repeat ($urandom_range(9, 12)) send(REQ_BYTE, {1'b1, 7'($urandom)}, 1'b0);
      end else begin
        ch = board.channel_for(stream_code);
        v = $urandom_range(0, 1023);
        if (ch >= 0 && $urandom_range(0, 4) != 0) begin
          lo = board.lower_bounds[VAL_W*ch +: VAL_W];
          hi = board.upper_bounds[VAL_W*ch +: VAL_W];
          if (ch == 0 && $urandom_range(0, 1) == 1) begin
            d = int'(board.fine_limit) + 4;
            v = int'(board.ch0_value) + int'($urandom_range(0, 2 * d)) - d;
          end else if (hi - lo >= 2) begin
            v = $urandom_range(lo + 1, hi - 1);
          end
        end
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        v10 = VAL_W'(v);
        send(REQ_BYTE, {1'b1, 1'($urandom), 2'($urandom), v10[9:6]}, 1'b0);
        send(REQ_BYTE, {1'b1, 1'($urandom), v10[5:0]}, 1'b0);
        nxt = (ch < 0) ? $urandom_range(0, 4) : (ch + 1) % NUM_CH;
        if ($urandom_range(0, 5) != 0) code = {1'b0, board.chan_codes[CODE_W*nxt +: CODE_W]};
        else code = {1'b0, 7'($urandom)};
        send(REQ_BYTE, code, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all codes zero, repeat byte zero, full-width bounds
    send(REQ_TICK, 8'hff, 1'b1);
    send(REQ_BYTE, 8'hff, 1'b0);
    send(REQ_BYTE, 8'hc1, 1'b0);
    send(REQ_BYTE, 8'h05, 1'b0);
    send(REQ_BYTE, 8'h7f, 1'b0);
    send(REQ_BYTE, 8'h80, 1'b0);
    send(REQ_BYTE, 8'h80, 1'b0);
    repeat (5) send(REQ_BYTE, 8'h00, 1'b0);
    send(REQ_BYTE, 8'hff, 1'b1);
    send(REQ_TICK, 8'h00, 1'b0);
    for (int i = 0; i < 10; i++) send(REQ_BYTE, 8'(8'h81 + 7 * i), 1'b0);
    send(REQ_BYTE, 8'h7f, 1'b1);
    send(REQ_TICK, 8'h00, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        3: set_config('0, '0, '0, '0, '0, '0, '0, '0);
        5: set_config('1, '1, '1, '1, '1, '1, '1, '1);
        6: pick_settings(1'b1);
        default: pick_settings(1'b0);
      endcase
      run_stream((phase == 3 || phase == 5) ? 50 : 110);
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.pending() == 0 && board.mismatches == 0) begin
      $display("source_param_stream_monitor_unit_tb: PASS");
    end else begin
      $display("source_param_stream_monitor_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("source_param_stream_monitor_unit_tb: FAIL");
    $finish;
  end

endmodule
